>>> sv/bdlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

  // Stream word widths (whole bytes)
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_LOW_PRESSED = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_HOLD   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_LONGER_HOLD = 2'd3;

  localparam logic        RST_LOW_PRESSED = 1'b1;
  localparam logic [15:0] RST_DEBOUNCE    = 16'd20;
  localparam logic [23:0] RST_LONG_HOLD   = 24'd1000;
  localparam logic [23:0] RST_LONGER_HOLD = 24'd5000;

  typedef enum logic [1:0] {
    PH_RELEASED    = 2'd0,
    PH_DEB_PRESS   = 2'd1,
    PH_PRESSED     = 2'd2,
    PH_DEB_RELEASE = 2'd3
  } phase_e;

  typedef struct packed {
    logic        low_pressed;
    logic [15:0] debounce_time;
    logic [23:0] long_hold_time;
    logic [23:0] longer_hold_time;
  } cfg_t;

  typedef struct packed {
    logic        take_longer;
    logic        take_long;
    logic        take_press;
    logic        do_poll;
    logic [31:0] time_now;
    logic        raw_level;
  } item_t;

  typedef struct packed {
    phase_e phase_now;
    logic   longer_flag;
    logic   long_flag;
    logic   press_flag;
  } res_t;

endpackage

`default_nettype wire

>>> sv/button_debounce_long_press.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                      Word
// s_axis    in   s_axis_tvalid_i/tready_o       one poll / flag access request
// m_axis    out  m_axis_tvalid_o/tready_i       flags before clearing + phase
// cfg       in   cfg_valid_i/cfg_ready_o        register index + write data
//
// One word per clock while the sink keeps m_axis_tready_i high; an accepted
// word is held in the input register, passes the poll logic and is then
// registered in the result register, from which the sink takes it.
// The input register is freed whenever the result register is empty or
// being taken, so a stalled result holds one word and one more waits.
// Reset: released phase, flags clear, registers at defaults 1/20/1000/5000.
// cfg_ready_o is always high; writes take effect on the next cycle.
module button_debounce_long_press (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // [0] raw_level, [32:1] time_now, [33] do_poll, [34] take_press,
  // [35] take_long, [36] take_longer, [39:37] zero
  input  wire logic [bdlp_pkg::InDataW-1:0]     s_axis_tdata_i,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [0] press_flag, [1] long_flag, [2] longer_flag, [4:3] phase_now, [7:5] zero
  output logic [bdlp_pkg::OutDataW-1:0]         m_axis_tdata_o,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bdlp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [bdlp_pkg::CfgDataW-1:0]    cfg_data_i
);

  bdlp_pkg::cfg_t  cfg_q;
  bdlp_pkg::item_t in_q;
  bdlp_pkg::res_t  out_q, res;
  logic            in_valid_q, out_valid_q;
  logic            advance, step, s_accept;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_pressed      <= bdlp_pkg::RST_LOW_PRESSED;
      cfg_q.debounce_time    <= bdlp_pkg::RST_DEBOUNCE;
      cfg_q.long_hold_time   <= bdlp_pkg::RST_LONG_HOLD;
      cfg_q.longer_hold_time <= bdlp_pkg::RST_LONGER_HOLD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bdlp_pkg::REG_LOW_PRESSED: cfg_q.low_pressed      <= cfg_data_i[0];
        bdlp_pkg::REG_DEBOUNCE:    cfg_q.debounce_time    <= cfg_data_i[15:0];
        bdlp_pkg::REG_LONG_HOLD:   cfg_q.long_hold_time   <= cfg_data_i[23:0];
        bdlp_pkg::REG_LONGER_HOLD: cfg_q.longer_hold_time <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: input word moves on when the result slot frees up
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) in_valid_q <= 1'b1;
      else if (step) in_valid_q <= 1'b0;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) in_q <= bdlp_pkg::item_t'(s_axis_tdata_i[36:0]);
    if (step) out_q <= res;
  end

  bdlp_poll u_poll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q};

endmodule

`default_nettype wire

>>> sv/bdlp_poll.sv
`timescale 1ns / 1ps
`default_nettype none

// Debounce / hold state and the combinational poll step.
module bdlp_poll (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire bdlp_pkg::item_t item_i,
  input  wire bdlp_pkg::cfg_t  cfg_i,
  output bdlp_pkg::res_t       res_o
);

  bdlp_pkg::phase_e phase_q, phase_d;
  logic        raw_seen_q, raw_seen_d;
  logic [31:0] stable_since_q, stable_since_d;
  logic [31:0] hold_start_q, hold_start_d;
  logic        hold_valid_q, hold_valid_d;
  logic        long_done_q, long_done_d;
  logic        longer_done_q, longer_done_d;
  logic [2:0]  flags_q, flags_d;

  logic        poll_en;
  logic        pressed;
  logic [31:0] since_elapsed;
  logic        stable;
  logic        acc_press, acc_release;
  logic [31:0] held;
  logic [2:0]  ev_set;
  logic [2:0]  flags_rep;

  assign poll_en = step_i & item_i.do_poll;

  // Polarity and debounce timer restart
  assign pressed        = cfg_i.low_pressed ? ~item_i.raw_level : item_i.raw_level;
  assign raw_seen_d     = pressed;
  assign stable_since_d = (pressed != raw_seen_q) ? item_i.time_now : stable_since_q;
  assign since_elapsed  = item_i.time_now - stable_since_d;
  assign stable         = since_elapsed >= {16'd0, cfg_i.debounce_time};

  // Next phase
  always_comb begin
    phase_d     = phase_q;
    acc_press   = 1'b0;
    acc_release = 1'b0;
    case (phase_q)
      bdlp_pkg::PH_RELEASED: begin
        if (raw_seen_d) phase_d = bdlp_pkg::PH_DEB_PRESS;
      end
      bdlp_pkg::PH_DEB_PRESS: begin
        if (!raw_seen_d) begin
          phase_d = bdlp_pkg::PH_RELEASED;
        end else if (stable) begin
          phase_d   = bdlp_pkg::PH_PRESSED;
          acc_press = 1'b1;
        end
      end
      bdlp_pkg::PH_PRESSED: begin
        if (!raw_seen_d) phase_d = bdlp_pkg::PH_DEB_RELEASE;
      end
      default: begin
        if (raw_seen_d) begin
          phase_d = bdlp_pkg::PH_PRESSED;
        end else if (stable) begin
          phase_d     = bdlp_pkg::PH_RELEASED;
          acc_release = 1'b1;
        end
      end
    endcase
  end

  // Hold timer and events
  assign held = item_i.time_now - hold_start_d;

  always_comb begin
    hold_start_d  = hold_start_q;
    hold_valid_d  = hold_valid_q;
    long_done_d   = long_done_q;
    longer_done_d = longer_done_q;
    ev_set        = 3'b000;
    if (acc_press) begin
      hold_start_d  = item_i.time_now;
      hold_valid_d  = 1'b1;
      long_done_d   = 1'b0;
      longer_done_d = 1'b0;
      ev_set[0]     = 1'b1;
    end
    if (acc_release) begin
      hold_start_d  = 32'd0;
      hold_valid_d  = 1'b0;
      long_done_d   = 1'b0;
      longer_done_d = 1'b0;
    end
    if (phase_d == bdlp_pkg::PH_PRESSED && hold_valid_d) begin
      if (!long_done_d && held >= {8'd0, cfg_i.long_hold_time}) begin
        long_done_d = 1'b1;
        ev_set[1]   = 1'b1;
      end
      // long-long only once long has fired, possibly in this same poll
      if (long_done_d && !longer_done_d && held >= {8'd0, cfg_i.longer_hold_time}) begin
        longer_done_d = 1'b1;
        ev_set[2]     = 1'b1;
      end
    end
  end

  assign flags_rep = item_i.do_poll ? (flags_q | ev_set) : flags_q;
  assign flags_d   = flags_rep & ~{item_i.take_longer, item_i.take_long, item_i.take_press};

  always_comb begin
    res_o.press_flag  = flags_rep[0];
    res_o.long_flag   = flags_rep[1];
    res_o.longer_flag = flags_rep[2];
    res_o.phase_now   = item_i.do_poll ? phase_d : phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= bdlp_pkg::PH_RELEASED;
      raw_seen_q     <= 1'b0;
      stable_since_q <= 32'd0;
      hold_start_q   <= 32'd0;
      hold_valid_q   <= 1'b0;
      long_done_q    <= 1'b0;
      longer_done_q  <= 1'b0;
      flags_q        <= 3'b000;
    end else begin
      if (poll_en) begin
        phase_q        <= phase_d;
        raw_seen_q     <= raw_seen_d;
        stable_since_q <= stable_since_d;
        hold_start_q   <= hold_start_d;
        hold_valid_q   <= hold_valid_d;
        long_done_q    <= long_done_d;
        longer_done_q  <= longer_done_d;
      end
      if (step_i) flags_q <= flags_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/bdlp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bdlp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic [bdlp_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // A ready sink never throttles the source
  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled with sink ready");

  // An accepted word is followed by result valid once it has passed the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> ##1 m_axis_tvalid_o)
    else $error("no result two cycles after accept");

  // Nothing pending straight out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid out of reset");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

`default_nettype wire

>>> tb/tb_button_debounce_long_press.sv
`timescale 1ns / 1ps

// Checks the debounced button with long and long-long press detection.
// Request words carry a pin level and a timestamp. They are driven in
// bursts: runs of steady level with contact bounce, random poll and take
// bits, and a share of fully random noise words. A scoreboard class keeps
// its own copy of the four-phase machine, the hold timer and the sticky
// flags. It predicts one result word per request and compares each
// returned word with the oldest prediction.
module tb_button_debounce_long_press;

  // Receiver stall styles, switched by bits [7:6] of the receiver cycle counter
  typedef enum logic [1:0] {
    RX_FREE   = 2'd0,
    RX_LIGHT  = 2'd1,
    RX_SPARSE = 2'd2,
    RX_HEAVY  = 2'd3
  } rx_mode_e;

  localparam logic [31:0] T_WRAP = 32'hFFFF_FC00;  // directed run crosses 2^32
  localparam int          ITEMS_PER_SETTING = 104;

  // ---------------------------------------------------------------------------
  // Flag scoreboard: tracks the button state, predicts each result word
  // ---------------------------------------------------------------------------
  class press_scoreboard;
    logic             low_pressed;
    logic [15:0]      deb_time;
    logic [23:0]      long_ms;
    logic [23:0]      longer_ms;
    bdlp_pkg::phase_e phase;
    logic             level_seen;   // polarity-corrected level of the last poll
    logic [31:0]      stable_since;
    logic [31:0]      hold_start;
    logic             hold_valid;
    logic             long_done;
    logic             longer_done;
    logic             press_ev;
    logic             long_ev;
    logic             longer_ev;
    bdlp_pkg::res_t   flags_q[$];
    int               mismatches;

    function new();
      low_pressed  = bdlp_pkg::RST_LOW_PRESSED;
      deb_time     = bdlp_pkg::RST_DEBOUNCE;
      long_ms      = bdlp_pkg::RST_LONG_HOLD;
      longer_ms    = bdlp_pkg::RST_LONGER_HOLD;
      phase        = bdlp_pkg::PH_RELEASED;
      level_seen   = 1'b0;
      stable_since = '0;
      hold_start   = '0;
      hold_valid   = 1'b0;
      long_done    = 1'b0;
      longer_done  = 1'b0;
      press_ev     = 1'b0;
      long_ev      = 1'b0;
      longer_ev    = 1'b0;
      mismatches   = 0;
    endfunction

    // Only the low bits of each register's width are kept
    function void write_reg(logic [bdlp_pkg::CfgIdxW-1:0] idx,
                            logic [bdlp_pkg::CfgDataW-1:0] value);
      case (idx)
        bdlp_pkg::REG_LOW_PRESSED: low_pressed = value[0];
        bdlp_pkg::REG_DEBOUNCE:    deb_time    = value[15:0];
        bdlp_pkg::REG_LONG_HOLD:   long_ms     = value[23:0];
        bdlp_pkg::REG_LONGER_HOLD: longer_ms   = value[23:0];
        default: ;
      endcase
    endfunction

    function void poll(logic level, logic [31:0] now);
      logic        pressed;
      logic        stable;
      logic [31:0] elapsed;
      logic [31:0] held;
      pressed = low_pressed ? ~level : level;
      if (pressed != level_seen) begin
        level_seen   = pressed;
        stable_since = now;
      end
      elapsed = now - stable_since;             // modulo 2^32
      stable  = elapsed >= 32'(deb_time);
      case (phase)
        bdlp_pkg::PH_RELEASED: begin
          if (level_seen) phase = bdlp_pkg::PH_DEB_PRESS;
        end
        bdlp_pkg::PH_DEB_PRESS: begin
          if (!level_seen) begin
            phase = bdlp_pkg::PH_RELEASED;
          end else if (stable) begin
            phase       = bdlp_pkg::PH_PRESSED;
            hold_start  = now;
            hold_valid  = 1'b1;
            long_done   = 1'b0;
            longer_done = 1'b0;
            press_ev    = 1'b1;
          end
        end
        bdlp_pkg::PH_PRESSED: begin
          if (!level_seen) phase = bdlp_pkg::PH_DEB_RELEASE;
        end
        default: begin
          // back to pressed keeps the running hold timer
          if (level_seen) begin
            phase = bdlp_pkg::PH_PRESSED;
          end else if (stable) begin
            phase       = bdlp_pkg::PH_RELEASED;
            hold_start  = '0;
            hold_valid  = 1'b0;
            long_done   = 1'b0;
            longer_done = 1'b0;
          end
        end
      endcase
      if (phase == bdlp_pkg::PH_PRESSED && hold_valid) begin
        held = now - hold_start;
        if (!long_done && held >= 32'(long_ms)) begin
          long_done = 1'b1;
          long_ev   = 1'b1;
        end
        // long-long only once long has fired; both may go in one poll
        if (long_done && !longer_done && held >= 32'(longer_ms)) begin
          longer_done = 1'b1;
          longer_ev   = 1'b1;
        end
      end
    endfunction

    // Called on every accepted request word
    function void note_input(bdlp_pkg::item_t it);
      bdlp_pkg::res_t r;
      if (it.do_poll) poll(it.raw_level, it.time_now);
      r.press_flag  = press_ev;
      r.long_flag   = long_ev;
      r.longer_flag = longer_ev;
      r.phase_now   = phase;
      flags_q.push_back(r);
      if (it.take_press)  press_ev  = 1'b0;
      if (it.take_long)   long_ev   = 1'b0;
      if (it.take_longer) longer_ev = 1'b0;
    endfunction

    function int pending();
      return flags_q.size();
    endfunction

    task report(string msg);
      if (mismatches < 50) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(bdlp_pkg::res_t got);
      bdlp_pkg::res_t want;
      if (flags_q.size() == 0) begin
        report($sformatf("result word %b with nothing pending", got));
        return;
      end
      want = flags_q.pop_front();
      if (got.press_flag !== want.press_flag)
        report($sformatf("press_flag %b, want %b", got.press_flag, want.press_flag));
      if (got.long_flag !== want.long_flag)
        report($sformatf("long_flag %b, want %b", got.long_flag, want.long_flag));
      if (got.longer_flag !== want.longer_flag)
        report($sformatf("longer_flag %b, want %b", got.longer_flag, want.longer_flag));
      if (got.phase_now !== want.phase_now)
        report($sformatf("phase_now %0d, want %0d", got.phase_now, want.phase_now));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // ---------------------------------------------------------------------------
  logic                          clk_i     = 1'b0;
  logic                          rst_ni    = 1'b0;
  logic [bdlp_pkg::InDataW-1:0]  s_tdata   = '0;
  logic                          s_tvalid  = 1'b0;
  logic                          m_tready  = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [bdlp_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [bdlp_pkg::CfgDataW-1:0] cfg_data  = '0;

  logic                          s_axis_tready_o;
  logic [bdlp_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                          m_axis_tvalid_o;
  logic                          cfg_ready_o;

  press_scoreboard sb;
  int              burst_left    = 0;   // words left in the current sender burst
  int              hold_off_left = 0;   // receiver long stall, counted in cycles
  bit [31:0]       rx_cycle      = '0;
  logic [31:0]     ms_now        = '0;  // running timestamp of the random part

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  button_debounce_long_press uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Result side: check each taken word, then pick the next tready.
  // Values read here are the ones the block saw at this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_tready) begin
      sb.check_result(bdlp_pkg::res_t'(m_axis_tdata_o[$bits(bdlp_pkg::res_t)-1:0]));
    end
    rx_cycle = rx_cycle + 1;
    if (hold_off_left > 0) begin
      // long hold-off: the block fills and must stall its input
      hold_off_left = hold_off_left - 1;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode_e'(rx_cycle[7:6]))
        RX_FREE:   m_tready <= 1'b1;
        RX_LIGHT:  m_tready <= ($urandom_range(0, 9) < 7);
        RX_SPARSE: m_tready <= (rx_cycle[1:0] == 2'd0);
        default:   m_tready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  function automatic bdlp_pkg::item_t word_of(logic raw, logic [31:0] t, logic do_poll,
                                              logic tp, logic tl, logic tlr);
    bdlp_pkg::item_t it;
    it.raw_level   = raw;
    it.time_now    = t;
    it.do_poll     = do_poll;
    it.take_press  = tp;
    it.take_long   = tl;
    it.take_longer = tlr;
    return it;
  endfunction

  // Offer one word; bursts of random length with random gaps in between.
  // Valid stays high across a burst, so it is never dropped and raised in
  // the same step.
  task automatic push_word(input bdlp_pkg::item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(bdlp_pkg::InDataW - $bits(bdlp_pkg::item_t)){1'b0}}, it};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(it);
    burst_left--;
  endtask

  task automatic idle_sender();
    s_tvalid  <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Holds cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [bdlp_pkg::CfgIdxW-1:0] idx,
                           input logic [bdlp_pkg::CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, value);
  endtask

  // Mostly runs of steady level with random bounce, timestamps moving on by
  // up to step_max ms or by an occasional big jump; some words are pure noise.
  task automatic run_random(input int count, input int unsigned step_max, input int run_max);
    bdlp_pkg::item_t it;
    int              run_left;
    logic            lvl;
    run_left = 0;
    lvl      = 1'($urandom_range(0, 1));
    for (int k = 0; k < count; k++) begin
      if (run_left == 0) begin
        lvl      = ~lvl;
        run_left = $urandom_range(1, run_max);
      end
      run_left--;
      ms_now = ms_now + $urandom_range(0, step_max);
      if ($urandom_range(0, 39) == 0) ms_now = ms_now + $urandom;  // big jump
      it.raw_level   = ($urandom_range(0, 11) == 0) ? ~lvl : lvl;   // contact bounce
      it.time_now    = ms_now;
      it.do_poll     = ($urandom_range(0, 9) != 0);
      it.take_press  = ($urandom_range(0, 2) == 0);
      it.take_long   = ($urandom_range(0, 2) == 0);
      it.take_longer = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise word: every field at random, time included
        it.raw_level   = 1'($urandom);
        it.time_now    = $urandom;
        it.do_poll     = 1'($urandom);
        it.take_press  = 1'($urandom);
        it.take_long   = 1'($urandom);
        it.take_longer = 1'($urandom);
      end
      push_word(it);
    end
  endtask

  // New register setting once the block is idle, then a random stretch
  task automatic run_setting(input logic [bdlp_pkg::CfgDataW-1:0] lp_v, deb_v, long_v,
                             longer_v,
                             input int unsigned step_max, input int run_max,
                             input int hold_off);
    wait_drained();
    write_reg(bdlp_pkg::REG_LOW_PRESSED, lp_v);
    write_reg(bdlp_pkg::REG_DEBOUNCE, deb_v);
    write_reg(bdlp_pkg::REG_LONG_HOLD, long_v);
    write_reg(bdlp_pkg::REG_LONGER_HOLD, longer_v);
    cfg_valid <= 1'b0;
    if (hold_off != 0) hold_off_left = hold_off;
    run_random(ITEMS_PER_SETTING, step_max, run_max);
    idle_sender();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset values: low level pressed, 20 / 1000 / 5000 ms.
    // The hold timer runs across the 2^32 wrap.
    push_word(word_of(1'b1, T_WRAP,           1'b1, 1'b0, 1'b0, 1'b0)); // released
    push_word(word_of(1'b0, T_WRAP + 32'd1,    1'b1, 1'b0, 1'b0, 1'b0)); // debouncing
    push_word(word_of(1'b1, T_WRAP + 32'd5,    1'b1, 1'b0, 1'b0, 1'b0)); // bounce back
    push_word(word_of(1'b0, T_WRAP + 32'd10,   1'b1, 1'b0, 1'b0, 1'b0));
    push_word(word_of(1'b0, T_WRAP + 32'd29,   1'b1, 1'b0, 1'b0, 1'b0)); // one ms short
    push_word(word_of(1'b0, T_WRAP + 32'd30,   1'b1, 1'b0, 1'b0, 1'b0)); // press
    push_word(word_of(1'b1, 32'hFFFF_FFFF,     1'b0, 1'b1, 1'b0, 1'b0)); // no poll, take
    push_word(word_of(1'b1, 32'h0000_0000,     1'b0, 1'b0, 1'b0, 1'b0)); // no poll
    push_word(word_of(1'b0, T_WRAP + 32'd1029, 1'b1, 1'b0, 1'b0, 1'b0)); // just under long
    push_word(word_of(1'b0, T_WRAP + 32'd1030, 1'b1, 1'b0, 1'b1, 1'b0)); // long fires
    push_word(word_of(1'b1, T_WRAP + 32'd1500, 1'b1, 1'b0, 1'b0, 1'b0)); // debouncing release
    push_word(word_of(1'b0, T_WRAP + 32'd1510, 1'b1, 1'b0, 1'b0, 1'b0)); // back, timer kept
    push_word(word_of(1'b0, T_WRAP + 32'd5030, 1'b1, 1'b1, 1'b1, 1'b1)); // long-long, past wrap
    push_word(word_of(1'b1, T_WRAP + 32'd5100, 1'b1, 1'b0, 1'b0, 1'b0));
    push_word(word_of(1'b1, T_WRAP + 32'd5119, 1'b1, 1'b0, 1'b0, 1'b0));
    push_word(word_of(1'b1, T_WRAP + 32'd5120, 1'b1, 1'b0, 1'b0, 1'b0)); // released
    // press at time zero is timed normally
    push_word(word_of(1'b0, 32'd0,    1'b1, 1'b0, 1'b0, 1'b0));
    push_word(word_of(1'b0, 32'd20,   1'b1, 1'b0, 1'b0, 1'b0));
    push_word(word_of(1'b0, 32'd1000, 1'b1, 1'b1, 1'b0, 1'b0));
    push_word(word_of(1'b0, 32'd1000, 1'b1, 1'b1, 1'b0, 1'b0)); // flag already taken
    push_word(word_of(1'b0, 32'd5000, 1'b1, 1'b0, 1'b0, 1'b0)); // long fires
    push_word(word_of(1'b0, 32'd9000, 1'b1, 1'b1, 1'b1, 1'b1)); // long-long fires; report and take all
    push_word(word_of(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1));
    idle_sender();

    ms_now = $urandom;
    // zero thresholds, active high: press, long and long-long in one poll
    run_setting(24'd0, 24'd0, 24'd0, 24'd0, 3, 10, 0);
    // short thresholds with a long receiver hold-off at the start
    run_setting(24'd1, 24'd3, 24'd10, 24'd25, 4, 14, 300);
    // debounce and hold registers at their top values, active high, big time steps
    run_setting(24'd0, 24'h00FFFF, 24'hFFFFFF, 24'hFFFFFF, 32'h0020_0000, 30, 0);
    // long-long threshold below long: both go together
    run_setting(24'd1, 24'd10, 24'd40, 24'd20, 5, 20, 0);
    // upper data bits must be dropped: high level pressed, debounce 5
    run_setting(24'hFFFFFE, 24'hAB0005, 24'd48, 24'd112, 6, 25, 0);
    run_setting(24'($urandom_range(0, 1)), 24'($urandom_range(0, 15)),
                24'($urandom_range(0, 80)), 24'($urandom_range(0, 200)), 8, 30, 250);
    run_setting(24'hFFFFFF, 24'd2, 24'd1, 24'd3, 2, 12, 0);
    // back to the reset values
    run_setting(24'(bdlp_pkg::RST_LOW_PRESSED), 24'(bdlp_pkg::RST_DEBOUNCE),
                bdlp_pkg::RST_LONG_HOLD, bdlp_pkg::RST_LONGER_HOLD, 300, 40, 0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #200_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
sv/bdlp_pkg.sv
sv/bdlp_poll.sv
sv/button_debounce_long_press.sv
sv/bdlp_checker.sv
tb/tb_button_debounce_long_press.sv
